@@ hw/rtl/ndem_pkg.sv @@
// Shared types, widths, codes and a helper function for the neighbour difference edge map.
// Used by the core, the checker and the testbench; no dependencies.
package ndem_pkg;

	localparam int CH_W      = 8;
	localparam int NUM_CH    = 4;
	localparam int PIX_W     = CH_W * NUM_CH;
	localparam int NUM_NB    = 4;
	localparam int DIFF_W    = 10;
	localparam int SUM_W     = 12;
	localparam int SQ_W      = 2 * SUM_W;
	localparam int CUBE_W    = 3 * SUM_W;
	localparam int EDGE_W    = 32;
	localparam int COORD_W   = 11;
	localparam int OUT_DW    = 56;
	localparam int CFG_W     = 12;
	localparam int CFG_IDX_W = 2;
	localparam int POWER_W   = 2;

	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_POWER  = 2'd2;

	localparam logic ACT_PIXEL = 1'b0;
	localparam logic ACT_FLUSH = 1'b1;

	localparam logic [POWER_W-1:0] POW_ZERO  = 2'd0;
	localparam logic [POWER_W-1:0] POW_ONE   = 2'd1;
	localparam logic [POWER_W-1:0] POW_TWO   = 2'd2;
	localparam logic [POWER_W-1:0] POW_THREE = 2'd3;

	typedef logic [PIX_W-1:0] pixel_t;

	function automatic logic [DIFF_W-1:0] pixel_diff(input pixel_t a, input pixel_t b);
		logic [DIFF_W-1:0] acc;
		logic [CH_W-1:0]   x;
		logic [CH_W-1:0]   y;
		acc = '0;
		for (int i = 0; i < NUM_CH; i++) begin
			x   = a[i*CH_W +: CH_W];
			y   = b[i*CH_W +: CH_W];
			acc = acc + DIFF_W'((x > y) ? (x - y) : (y - x));
		end
		return acc;
	endfunction

endpackage

@@ hw/rtl/neighbour_difference_edge_map_core.sv @@
// One item is in work at a time, as s_tready is high only in the idle state. An item with a
// result takes two read passes on the two-port line store, the difference, the add, two
// multiplies and an output state that waits on m_tready; row-0 pixels take only the first pass.
// Reset (arst_n low): counters, phase and output valid clear; width 640, height 480, power 1.
// The line store has no reset; entries are defined once written.
// Top level of the edge map: line store, sequencer, difference and power datapath.
// Depends on ndem_pkg.
module neighbour_difference_edge_map_core #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 2048
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wen,
	input  logic [ndem_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ndem_pkg::CFG_W-1:0]    cfg_data,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [ndem_pkg::PIX_W-1:0]    s_tdata,  // red, green, blue, alpha
	input  logic                          s_tuser,  // action
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [ndem_pkg::OUT_DW-1:0]   m_tdata,  // edge_value, out_col, out_row, zero pad
	output logic                          m_tlast   // frame_end
);

	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int WW  = $clog2(MAX_WIDTH + 1);
	localparam int WCW = (WW > ndem_pkg::CFG_W) ? WW : ndem_pkg::CFG_W;
	localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int HW  = $clog2(MAX_HEIGHT + 1);
	localparam int HCW = (HW > ndem_pkg::CFG_W) ? HW : ndem_pkg::CFG_W;
	localparam int AW  = $clog2(2 * MAX_WIDTH);
	localparam int DEPTH = 2 * MAX_WIDTH;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RDA  = 3'd1;
	localparam logic [2:0] ST_RDB  = 3'd2;
	localparam logic [2:0] ST_DIFF = 3'd3;
	localparam logic [2:0] ST_ADD  = 3'd4;
	localparam logic [2:0] ST_MUL1 = 3'd5;
	localparam logic [2:0] ST_MUL2 = 3'd6;
	localparam logic [2:0] ST_OUT  = 3'd7;

	// config and control state
	logic [ndem_pkg::CFG_W-1:0]   width_q;
	logic [ndem_pkg::CFG_W-1:0]   height_q;
	logic [ndem_pkg::POWER_W-1:0] power_q;
	logic [2:0]                   state_q;
	logic [CW-1:0]                col_q;
	logic [RW-1:0]                row_q;
	logic                         flush_q;
	logic                         m_tvalid_q;

	// job registers
	ndem_pkg::pixel_t             pix_q;
	logic [AW-1:0]                addr_c_q, addr_u_q, addr_l_q, addr_r_q;
	logic                         has_up_q, has_dn_q, has_l_q, has_r_q;
	logic                         res_q, wr_q, end_q;
	logic [ndem_pkg::COORD_W-1:0] res_col_q, res_row_q;

	// datapath registers
	ndem_pkg::pixel_t             mem [DEPTH];
	ndem_pkg::pixel_t             rd0_q, rd1_q, centre_q, up_q;
	logic [ndem_pkg::DIFF_W-1:0]  diff_q [ndem_pkg::NUM_NB];
	logic [ndem_pkg::SUM_W-1:0]   sum_q;
	logic [ndem_pkg::SQ_W-1:0]    sq_q;
	logic [ndem_pkg::CUBE_W-1:0]  cube_q;
	logic [ndem_pkg::OUT_DW-1:0]  m_tdata_q;
	logic                         m_tlast_q;

	// combinational
	logic [WW-1:0]          eff_w, col_inc;
	logic [HW-1:0]          eff_h, h_dec;
	logic [HW:0]            row_inc;
	logic                   last_col, last_row, accept, pix_ok, fl_ok;
	logic                   par_up, has_up;
	logic [CW-1:0]          col_l, col_r;
	logic [RW-1:0]          row_dec;
	logic [AW-1:0]          rd_addr0, rd_addr1;
	logic                   mem_we, out_free;
	logic [ndem_pkg::EDGE_W-1:0] edge_val;

	function automatic logic [AW-1:0] slot(input logic par, input logic [CW-1:0] col);
		return (par ? AW'(MAX_WIDTH) : AW'(0)) + AW'(col);
	endfunction

	always_comb begin
		if (width_q == '0) begin
			eff_w = WW'(1);
		end else if (WCW'(width_q) > WCW'(MAX_WIDTH)) begin
			eff_w = WW'(MAX_WIDTH);
		end else begin
			eff_w = WW'(width_q);
		end
		if (height_q == '0) begin
			eff_h = HW'(1);
		end else if (HCW'(height_q) > HCW'(MAX_HEIGHT)) begin
			eff_h = HW'(MAX_HEIGHT);
		end else begin
			eff_h = HW'(height_q);
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign pix_ok   = !flush_q && (s_tuser == ndem_pkg::ACT_PIXEL);
	assign fl_ok    = flush_q && (s_tuser == ndem_pkg::ACT_FLUSH);

	assign col_inc  = WW'(col_q) + WW'(1);
	assign last_col = (col_inc >= eff_w);
	assign row_inc  = (HW+1)'(row_q) + (HW+1)'(1);
	assign last_row = (row_inc >= (HW+1)'(eff_h));
	assign row_dec  = row_q - RW'(1);
	assign h_dec    = eff_h - HW'(1);
	assign col_l    = (col_q == '0) ? '0 : col_q - CW'(1);
	assign col_r    = (col_q == CW'(MAX_WIDTH - 1)) ? '0 : col_q + CW'(1);
	assign par_up   = flush_q ? eff_h[0] : row_q[0];
	assign has_up   = flush_q ? ((HW+1)'(eff_h) >= (HW+1)'(2)) : ((RW+1)'(row_q) >= (RW+1)'(2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q    <= ndem_pkg::CFG_W'(640);
			height_q   <= ndem_pkg::CFG_W'(480);
			power_q    <= ndem_pkg::POW_ONE;
			state_q    <= ST_IDLE;
			col_q      <= '0;
			row_q      <= '0;
			flush_q    <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_wen) begin
				case (cfg_index)
					ndem_pkg::REG_WIDTH:  width_q  <= cfg_data;
					ndem_pkg::REG_HEIGHT: height_q <= cfg_data;
					ndem_pkg::REG_POWER:  power_q  <= cfg_data[ndem_pkg::POWER_W-1:0];
					default: ;
				endcase
			end

			if (state_q == ST_OUT && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept && pix_ok) begin
						state_q <= ST_RDA;
						if (last_col) begin
							col_q <= '0;
							if (last_row) begin
								flush_q <= 1'b1;
								row_q   <= '0;
							end else begin
								row_q <= RW'(row_inc);
							end
						end else begin
							col_q <= CW'(col_inc);
						end
					end else if (accept && fl_ok) begin
						state_q <= ST_RDA;
						if (last_col) begin
							flush_q <= 1'b0;
							col_q   <= '0;
							row_q   <= '0;
						end else begin
							col_q <= CW'(col_inc);
						end
					end
				end
				ST_RDA:  state_q <= res_q ? ST_RDB : ST_IDLE;
				ST_RDB:  state_q <= ST_DIFF;
				ST_DIFF: state_q <= ST_ADD;
				ST_ADD:  state_q <= ST_MUL1;
				ST_MUL1: state_q <= ST_MUL2;
				ST_MUL2: state_q <= ST_OUT;
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// job capture at transfer
	always_ff @(posedge clk) begin
		if (accept) begin
			pix_q     <= s_tdata;
			addr_u_q  <= slot(par_up, col_q);
			addr_c_q  <= slot(!par_up, col_q);
			addr_l_q  <= slot(!par_up, col_l);
			addr_r_q  <= slot(!par_up, col_r);
			has_up_q  <= has_up;
			has_dn_q  <= !flush_q;
			has_l_q   <= (col_q != '0);
			has_r_q   <= !last_col;
			wr_q      <= pix_ok;
			res_q     <= (pix_ok && row_q != '0) || fl_ok;
			end_q     <= fl_ok && last_col;
			res_col_q <= ndem_pkg::COORD_W'(col_q);
			res_row_q <= flush_q ? ndem_pkg::COORD_W'(h_dec) : ndem_pkg::COORD_W'(row_dec);
		end
	end

	// line store: two read ports, one write port, read-first
	assign mem_we   = (state_q == ST_RDA) && wr_q;
	assign rd_addr0 = (state_q == ST_RDB) ? addr_l_q : addr_c_q;
	assign rd_addr1 = (state_q == ST_RDB) ? addr_r_q : addr_u_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[addr_u_q] <= pix_q;
		end
		rd0_q <= mem[rd_addr0];
		rd1_q <= mem[rd_addr1];
	end

	// difference and power datapath
	always_ff @(posedge clk) begin
		if (state_q == ST_RDB) begin
			centre_q <= rd0_q;
			up_q     <= rd1_q;
		end
		if (state_q == ST_DIFF) begin
			diff_q[0] <= has_up_q ? ndem_pkg::pixel_diff(centre_q, up_q) : '0;
			diff_q[1] <= has_dn_q ? ndem_pkg::pixel_diff(centre_q, pix_q) : '0;
			diff_q[2] <= has_l_q ? ndem_pkg::pixel_diff(centre_q, rd0_q) : '0;
			diff_q[3] <= has_r_q ? ndem_pkg::pixel_diff(centre_q, rd1_q) : '0;
		end
		if (state_q == ST_ADD) begin
			sum_q <= ndem_pkg::SUM_W'(diff_q[0]) + ndem_pkg::SUM_W'(diff_q[1])
			       + ndem_pkg::SUM_W'(diff_q[2]) + ndem_pkg::SUM_W'(diff_q[3]);
		end
		if (state_q == ST_MUL1) begin
			sq_q <= ndem_pkg::SQ_W'(sum_q) * ndem_pkg::SQ_W'(sum_q);
		end
		if (state_q == ST_MUL2) begin
			cube_q <= ndem_pkg::CUBE_W'(sq_q) * ndem_pkg::CUBE_W'(sum_q);
		end
		if (state_q == ST_OUT && out_free) begin
			m_tdata_q <= ndem_pkg::OUT_DW'({res_row_q, res_col_q, edge_val});
			m_tlast_q <= end_q;
		end
	end

	always_comb begin
		case (power_q)
			ndem_pkg::POW_ZERO:  edge_val = ndem_pkg::EDGE_W'(1);
			ndem_pkg::POW_ONE:   edge_val = ndem_pkg::EDGE_W'(sum_q);
			ndem_pkg::POW_TWO:   edge_val = ndem_pkg::EDGE_W'(sq_q);
			ndem_pkg::POW_THREE: edge_val = (cube_q[ndem_pkg::CUBE_W-1:ndem_pkg::EDGE_W] != '0)
			                                ? '1 : cube_q[ndem_pkg::EDGE_W-1:0];
			default:             edge_val = '0;
		endcase
	end

	assign out_free = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

endmodule

@@ verif/neighbour_difference_edge_map_checker.sv @@
`timescale 1ns / 1ps
// Checker for the edge map core. It follows the register writes and both stream channels,
// keeps its own line store and counters, and compares each output transfer with the oldest
// predicted result (edge value, column, row and frame end). Depends on ndem_pkg.
module neighbour_difference_edge_map_checker #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 2048
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wen,
	input  logic [ndem_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ndem_pkg::CFG_W-1:0]    cfg_data,
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	input  logic [ndem_pkg::PIX_W-1:0]    s_tdata,
	input  logic                          s_tuser,
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic [ndem_pkg::OUT_DW-1:0]   m_tdata,
	input  logic                          m_tlast,
	output int                            errors,
	output int                            pending
);
	import ndem_pkg::*;

	typedef struct {
		logic [EDGE_W-1:0]  value;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
		logic               last;
	} edge_result_t;

	edge_result_t       edges_due[$];
	logic [PIX_W-1:0]   line_buf [0:2*MAX_WIDTH-1];
	int unsigned        col_pos;
	int unsigned        row_pos;
	bit                 in_flush;
	logic [CFG_W-1:0]   width_reg;
	logic [CFG_W-1:0]   height_reg;
	logic [POWER_W-1:0] power_reg;

	function automatic int unsigned clamp_dim(logic [CFG_W-1:0] v, int unsigned limit);
		if (v < 1) return 1;
		if (v > limit) return limit;
		return v;
	endfunction

	function automatic int unsigned buf_index(int unsigned row, int unsigned col);
		return (row % 2) * MAX_WIDTH + col % MAX_WIDTH;
	endfunction

	function automatic int unsigned rgba_distance(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b);
		int unsigned total;
		int          x;
		int          y;
		total = 0;
		for (int i = 0; i < NUM_CH; i++) begin
			x = a[i*CH_W +: CH_W];
			y = b[i*CH_W +: CH_W];
			total += (x > y) ? x - y : y - x;
		end
		return total;
	endfunction

	function automatic logic [EDGE_W-1:0] raise_saturated(int unsigned sum);
		logic [63:0] acc;
		acc = 64'd1;
		for (int i = 0; i < power_reg; i++)
			acc = acc * sum;
		return (acc > 64'hFFFF_FFFF) ? '1 : acc[EDGE_W-1:0];
	endfunction

	// centre and row-mates come from the line store; up/down are passed in
	function automatic logic [EDGE_W-1:0] predict_edge(int unsigned row, int unsigned col,
			bit has_up, logic [PIX_W-1:0] up, bit has_down, logic [PIX_W-1:0] down,
			int unsigned w);
		logic [PIX_W-1:0] centre;
		int unsigned      sum;
		centre = line_buf[buf_index(row, col)];
		sum = 0;
		if (has_up)
			sum += rgba_distance(centre, up);
		if (has_down)
			sum += rgba_distance(centre, down);
		if (col >= 1)
			sum += rgba_distance(centre, line_buf[buf_index(row, col - 1)]);
		if (col + 1 < w)
			sum += rgba_distance(centre, line_buf[buf_index(row, col + 1)]);
		return raise_saturated(sum);
	endfunction

	task automatic compare_field(string name, longint unsigned want, longint unsigned got);
		if (want != got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		edge_result_t     seen;
		edge_result_t     want;
		edge_result_t     fresh;
		logic [PIX_W-1:0] up;
		int unsigned      w;
		int unsigned      h;
		int unsigned      r;
		int unsigned      c;
		if (!arst_n) begin
			edges_due.delete();
			col_pos    = 0;
			row_pos    = 0;
			in_flush   = 1'b0;
			width_reg  = 12'd640;
			height_reg = 12'd480;
			power_reg  = POW_ONE;
			errors     = 0;
			pending    = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				seen.value = m_tdata[EDGE_W-1:0];
				seen.col   = m_tdata[EDGE_W +: COORD_W];
				seen.row   = m_tdata[EDGE_W+COORD_W +: COORD_W];
				seen.last  = m_tlast;
				if (edges_due.size() == 0) begin
					errors++;
					$display("%0t: output transfer, expected none, got value %0h col %0d row %0d",
						$time, seen.value, seen.col, seen.row);
				end else begin
					want = edges_due.pop_front();
					compare_field("edge_value", want.value, seen.value);
					compare_field("out_col", want.col, seen.col);
					compare_field("out_row", want.row, seen.row);
					compare_field("frame_end", want.last, seen.last);
				end
			end

			if (cfg_wen) begin
				case (cfg_index)
					REG_WIDTH:  width_reg  = cfg_data;
					REG_HEIGHT: height_reg = cfg_data;
					REG_POWER:  power_reg  = cfg_data[POWER_W-1:0];
					default: ;
				endcase
			end

			if (s_tvalid && s_tready) begin
				w = clamp_dim(width_reg, MAX_WIDTH);
				h = clamp_dim(height_reg, MAX_HEIGHT);
				r = row_pos;
				c = col_pos % MAX_WIDTH;
				if (!in_flush) begin
					if (s_tuser == ACT_PIXEL) begin
						if (r >= 1) begin
							up          = line_buf[buf_index(r, c)];
							fresh.value = predict_edge(r - 1, c, r >= 2, up, 1'b1, s_tdata, w);
							fresh.col   = COORD_W'(c);
							fresh.row   = COORD_W'(r - 1);
							fresh.last  = 1'b0;
							edges_due   = {edges_due, fresh};
						end
						line_buf[buf_index(r, c)] = s_tdata;
						if (c + 1 >= w) begin
							col_pos = 0;
							row_pos = r + 1;
							if (row_pos >= h) begin
								in_flush = 1'b1;
								row_pos  = 0;
							end
						end else begin
							col_pos = c + 1;
						end
					end
				end else if (s_tuser == ACT_FLUSH) begin
					up          = (h >= 2) ? line_buf[buf_index(h, c)] : '0;
					fresh.value = predict_edge(h - 1, c, h >= 2, up, 1'b0, '0, w);
					fresh.col   = COORD_W'(c);
					fresh.row   = COORD_W'(h - 1);
					fresh.last  = (c + 1 >= w);
					edges_due   = {edges_due, fresh};
					if (fresh.last) begin
						in_flush = 1'b0;
						col_pos  = 0;
						row_pos  = 0;
					end else begin
						col_pos = c + 1;
					end
				end
			end
			pending = edges_due.size();
		end
	end

endmodule

@@ verif/neighbour_difference_edge_map_core_test.sv @@
`timescale 1ns / 1ps
// Top of the edge map testbench: clock, reset, register setup, frame stimulus with random
// gaps on both streams, and the verdict. Depends on ndem_pkg, the core and the checker.
module neighbour_difference_edge_map_core_test;
	import ndem_pkg::*;

	localparam int MAX_WIDTH    = 2048;
	localparam int MAX_HEIGHT   = 2048;
	localparam int ITEM_TARGET  = 1600;
	localparam int CALM_TAIL    = 250;
	localparam int DRAIN_CYCLES = 12;
	localparam int HOLD_CYCLES  = 400;

	typedef enum int {PIX_NOISE, PIX_EXTREME, PIX_SMOOTH, PIX_CHECKER} pixel_style_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cfg_wen   = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data  = '0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [PIX_W-1:0]     s_tdata   = '0;  // red, green, blue, alpha
	logic                 s_tuser   = ACT_PIXEL;  // action
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [OUT_DW-1:0]    m_tdata;  // edge_value, out_col, out_row, zero pad
	logic                 m_tlast;  // frame_end
	int                   errors;
	int                   pending;
	bit                   gaps_on   = 1'b1;
	bit                   hold_req  = 1'b0;
	int                   fed       = 0;

	neighbour_difference_edge_map_core #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	neighbour_difference_edge_map_checker #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) edge_check (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.errors   (errors),
		.pending  (pending)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("simulation failed");
		$finish;
	end

	// receiver: random stalls, one long hold-off on request
	initial begin
		forever begin
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else if (gaps_on && $urandom_range(0, 2) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
		end
	end

	function automatic int clamp_dim(int v, int limit);
		if (v < 1) return 1;
		if (v > limit) return limit;
		return v;
	endfunction

	function automatic logic [PIX_W-1:0] make_pixel(pixel_style_t style, int idx);
		logic [PIX_W-1:0] p;
		p = '0;
		case (style)
			PIX_EXTREME:
				for (int i = 0; i < NUM_CH; i++)
					p[i*CH_W +: CH_W] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
			PIX_SMOOTH:
				for (int i = 0; i < NUM_CH; i++)
					p[i*CH_W +: CH_W] = 8'd120 + 8'($urandom_range(0, 15));
			PIX_CHECKER: p = idx[0] ? '1 : '0;
			default: p = $urandom;
		endcase
		return p;
	endfunction

	task automatic push_item(input logic act, input logic [PIX_W-1:0] pix);
		if (gaps_on && $urandom_range(0, 7) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= pix;
		s_tuser  <= act;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic send_pixels(input int count, input pixel_style_t style, input bit noisy);
		for (int i = 0; i < count; i++) begin
			if (noisy && $urandom_range(0, 15) == 0)
				push_item(ACT_FLUSH, $urandom);
			push_item(ACT_PIXEL, make_pixel(style, i));
			fed++;
		end
	endtask

	task automatic send_flushes(input int count, input bit noisy);
		for (int i = 0; i < count; i++) begin
			if (noisy && $urandom_range(0, 15) == 0)
				push_item(ACT_PIXEL, $urandom);
			push_item(ACT_FLUSH, $urandom);
			fed++;
		end
	endtask

	task automatic send_frame(input int w_reg, input int h_reg, input pixel_style_t style,
			input bit noisy);
		int w;
		int h;
		w = clamp_dim(w_reg, MAX_WIDTH);
		h = clamp_dim(h_reg, MAX_HEIGHT);
		send_pixels(w * h, style, noisy);
		send_flushes(w, noisy);
	endtask

	// stop offering, wait for every predicted value, then let the pipeline empty
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
		cfg_wen   <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val[CFG_W-1:0];
		@(posedge clk);
		cfg_wen <= 1'b0;
		@(posedge clk);
	endtask

	task automatic program_frame(input int w_reg, input int h_reg, input int unsigned pw);
		write_reg(REG_WIDTH, w_reg);
		write_reg(REG_HEIGHT, h_reg);
		write_reg(REG_POWER, pw);
	endtask

	initial begin
		int  w_reg;
		int  h_reg;
		bit  pressed;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// one-pixel frame, with stray items of the wrong kind in both phases
		program_frame(1, 1, POW_ONE);
		push_item(ACT_FLUSH, '1);
		push_item(ACT_PIXEL, '1);
		push_item(ACT_PIXEL, '0);
		push_item(ACT_FLUSH, '0);
		settle();
		program_frame(3, 3, POW_THREE);
		send_frame(3, 3, PIX_CHECKER, 1'b0);
		settle();
		program_frame(2, 1, POW_ZERO);
		send_frame(2, 1, PIX_EXTREME, 1'b0);
		settle();
		program_frame(0, 0, POW_TWO);
		send_frame(0, 0, PIX_NOISE, 1'b0);

		// height lowered below the current row mid-frame
		settle();
		program_frame(5, 6, POW_TWO);
		send_pixels(15, PIX_NOISE, 1'b0);
		settle();
		write_reg(REG_HEIGHT, 2);
		send_pixels(5, PIX_NOISE, 1'b0);
		send_flushes(5, 1'b0);

		// width lowered mid-row
		settle();
		program_frame(6, 3, POW_ONE);
		send_pixels(9, PIX_SMOOTH, 1'b0);
		settle();
		write_reg(REG_WIDTH, 2);
		send_pixels(3, PIX_SMOOTH, 1'b0);
		send_flushes(2, 1'b0);

		// register values above the maximum, then cut down mid-row
		settle();
		program_frame(4095, 4095, POW_ONE);
		send_pixels(10, PIX_NOISE, 1'b1);
		settle();
		program_frame(3, 2, POW_THREE);
		send_pixels(4, PIX_EXTREME, 1'b1);
		send_flushes(3, 1'b1);

		fed     = 0;
		pressed = 1'b0;
		while (fed < ITEM_TARGET) begin
			settle();
			if (fed >= ITEM_TARGET - CALM_TAIL)
				gaps_on = 1'b0;
			case ($urandom_range(0, 19))
				0:          w_reg = 0;
				1, 2, 3, 4: w_reg = $urandom_range(9, 40);
				default:    w_reg = $urandom_range(1, 8);
			endcase
			h_reg = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 6);
			if (!pressed && fed >= 400) begin
				w_reg    = 24;
				h_reg    = 4;
				pressed  = 1'b1;
				hold_req = 1'b1;
			end
			program_frame(w_reg, h_reg, $urandom_range(0, 3));
			repeat ($urandom_range(1, 3))
				send_frame(w_reg, h_reg, pixel_style_t'($urandom_range(0, 3)),
					$urandom_range(0, 1));
		end
		settle();

		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
